// ===== rtl/nnr_pkg.sv =====
// Package for the nearest-neighbour resampler: shared constants, register
// indexes, configuration and phase-unit structs, sequencer state type.
// No dependencies.
package nnr_pkg;

	localparam int PHASE_W    = 32;
	localparam int APB_DATA_W = 32;
	localparam int CFG_ADDR_W = 3;
	localparam int REG_IDX_W  = 1;

	localparam logic [REG_IDX_W-1:0] REG_PHASE_STEP    = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_UPSAMPLE_MODE = 1'b1;

	typedef struct packed {
		logic [PHASE_W-1:0] phase_step;
		logic               upsample_mode;
	} nnr_cfg_t;

	typedef struct packed {
		logic [PHASE_W-1:0] sum;
		logic               wrapped;
	} nnr_phase_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DEC  = 3'b010,
		ST_UP   = 3'b100
	} nnr_state_t;

endpackage

// ===== rtl/nnr_in_if.sv =====
// Input stream interface: valid/ready handshake carrying one I/Q sample.
// No dependencies.
interface nnr_in_if #(
	parameter int SAMPLE_WIDTH = 16
);
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] sample_i;
	logic signed [SAMPLE_WIDTH-1:0] sample_q;

	modport source (output valid, output sample_i, output sample_q, input ready);
	modport sink   (input valid, input sample_i, input sample_q, output ready);
endinterface

// ===== rtl/nnr_out_if.sv =====
// Output stream interface: valid/ready handshake carrying one resampled I/Q
// item and its end-of-run mark. No dependencies.
interface nnr_out_if #(
	parameter int SAMPLE_WIDTH = 16
);
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] out_i;
	logic signed [SAMPLE_WIDTH-1:0] out_q;
	logic                           last_of_run;

	modport source (output valid, output out_i, output out_q, output last_of_run,
		input ready);
	modport sink   (input valid, input out_i, input out_q, input last_of_run,
		output ready);
endinterface

// ===== rtl/nnr_apb_regs.sv =====
// APB register bank: phase step and mode registers, write and read decode.
// Depends on nnr_pkg.
module nnr_apb_regs import nnr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	output nnr_cfg_t              cfg
);
	logic [PHASE_W-1:0]   phase_step_q;
	logic                 upsample_mode_q;
	logic [REG_IDX_W-1:0] reg_idx;
	logic                 wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[CFG_ADDR_W-1:2];
	assign wr_en   = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_step_q    <= '0;
			upsample_mode_q <= 1'b0;
		end else if (wr_en) begin
			case (reg_idx)
				REG_PHASE_STEP:    phase_step_q    <= pwdata[PHASE_W-1:0];
				REG_UPSAMPLE_MODE: upsample_mode_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_PHASE_STEP:    prdata = phase_step_q;
			REG_UPSAMPLE_MODE: prdata = {{(APB_DATA_W-1){1'b0}}, upsample_mode_q};
			default:           prdata = '0;
		endcase
	end

	assign cfg.phase_step    = phase_step_q;
	assign cfg.upsample_mode = upsample_mode_q;

endmodule

// ===== rtl/nnr_phase_unit.sv =====
// Shared phase unit: optional step clamp, 32-bit accumulator add and wrap
// detect. Depends on nnr_pkg.
module nnr_phase_unit import nnr_pkg::*; #(
	parameter int MAX_RUN = 64
) (
	input  logic [PHASE_W-1:0] acc,
	input  logic [PHASE_W-1:0] step,
	input  logic               clamp,
	output nnr_phase_t         res
);
	// smallest interpolation step: ceil(2^32 / MAX_RUN)
	localparam logic [63:0] MIN_UP_STEP_W =
		(64'd4294967296 + 64'(MAX_RUN) - 64'd1) / 64'(MAX_RUN);
	localparam logic [PHASE_W-1:0] MIN_UP_STEP = MIN_UP_STEP_W[PHASE_W-1:0];

	logic [PHASE_W-1:0] step_eff;
	logic [PHASE_W:0]   sum_w;

	always_comb begin
		step_eff    = (clamp && (step < MIN_UP_STEP)) ? MIN_UP_STEP : step;
		sum_w       = {1'b0, acc} + {1'b0, step_eff};
		res.sum     = sum_w[PHASE_W-1:0];
		// new <= old: carry out, or nothing added
		res.wrapped = sum_w[PHASE_W] | (step_eff == '0);
	end

endmodule

// ===== rtl/nearest_neighbour_resampler_core.sv =====
// Nearest-neighbour I/Q resampler with a 32-bit phase accumulator.
// A decimate item is accepted, then takes one accumulator step; an
// interpolate item is accepted, then gives a run of k outputs, k <= MAX_RUN,
// which may open with the output owed by the previous item's wrap. Steps are
// made by one accumulator add per cycle in the shared phase unit, held while
// the output side stalls. A new item is accepted only once the last is done.
// Reset (arst_n, asynchronous, active low) clears control registers and
// accumulator and arms the first item to pass.
module nearest_neighbour_resampler_core import nnr_pkg::*; #(
	parameter int SAMPLE_WIDTH = 16,
	parameter int MAX_RUN      = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	nnr_in_if.sink                samples,
	nnr_out_if.source             resampled,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);
	// run counter must hold MAX_RUN itself
	localparam int RUN_W = $clog2(MAX_RUN + 1);
	localparam logic [RUN_W-1:0] RUN_LIMIT = RUN_W'(MAX_RUN);

	nnr_cfg_t   cfg;
	nnr_phase_t ph;
	nnr_state_t state_q;

	// captured input item
	logic signed [SAMPLE_WIDTH-1:0] smp_i_q;
	logic signed [SAMPLE_WIDTH-1:0] smp_q_q;

	// resampler state
	logic [PHASE_W-1:0] phase_acc_q;
	logic               take_next_q;
	logic               wrap_pending_q;
	// an output of the current sample is owed, its end-of-run mark not yet known
	logic               pend_q;
	logic [RUN_W-1:0]   run_cnt_q;

	// output register
	logic                           out_valid_q;
	logic signed [SAMPLE_WIDTH-1:0] out_i_q;
	logic signed [SAMPLE_WIDTH-1:0] out_q_q;
	logic                           out_last_q;

	logic in_acc;
	logic out_free;
	logic emit;
	logic emit_last;

	nnr_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// one adder serves both modes; clamp the step only when interpolating
	nnr_phase_unit #(
		.MAX_RUN (MAX_RUN)
	) u_phase (
		.acc   (phase_acc_q),
		.step  (cfg.phase_step),
		.clamp (state_q == ST_UP),
		.res   (ph)
	);

	assign samples.ready = (state_q == ST_IDLE);
	assign in_acc        = samples.valid & samples.ready;
	// output register can take a new item this cycle
	assign out_free      = ~out_valid_q | resampled.ready;

	// Work out whether the sequencer hands an item to the output register now,
	// and whether that item closes the run.
	always_comb begin
		emit      = 1'b0;
		emit_last = 1'b0;
		case (state_q)
			ST_DEC: begin
				emit      = take_next_q & out_free;
				emit_last = 1'b1;
			end
			ST_UP: begin
				if (pend_q && out_free) begin
					emit = 1'b1;
					// run is full, or the next step wraps and is owed elsewhere
					emit_last = (run_cnt_q == RUN_LIMIT) | ph.wrapped;
				end
			end
			default: ;
		endcase
	end

	// capture the input item; payload needs no reset
	always_ff @(posedge clk) begin
		if (in_acc) begin
			smp_i_q <= samples.sample_i;
			smp_q_q <= samples.sample_q;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			phase_acc_q    <= '0;
			take_next_q    <= 1'b1;
			wrap_pending_q <= 1'b0;
			pend_q         <= 1'b0;
			run_cnt_q      <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (cfg.upsample_mode) begin
							// a wrap from the last item owes this sample one output
							pend_q         <= wrap_pending_q;
							run_cnt_q      <= wrap_pending_q ? RUN_W'(1) : '0;
							wrap_pending_q <= 1'b0;
							state_q        <= ST_UP;
						end else begin
							state_q <= ST_DEC;
						end
					end
				end
				ST_DEC: begin
					// hold while a passed item cannot reach the output register
					if (!take_next_q || out_free) begin
						phase_acc_q <= ph.sum;
						take_next_q <= ph.wrapped;
						state_q     <= ST_IDLE;
					end
				end
				ST_UP: begin
					if (run_cnt_q == RUN_LIMIT) begin
						// run full: drop out without another step
						if (out_free) begin
							pend_q      <= 1'b0;
							take_next_q <= 1'b0;
							state_q     <= ST_IDLE;
						end
					end else if (!pend_q || out_free) begin
						phase_acc_q <= ph.sum;
						if (ph.wrapped) begin
							// the wrapped step's output goes to the next item
							wrap_pending_q <= 1'b1;
							take_next_q    <= 1'b1;
							pend_q         <= 1'b0;
							state_q        <= ST_IDLE;
						end else begin
							pend_q    <= 1'b1;
							run_cnt_q <= run_cnt_q + RUN_W'(1);
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output register: load on emit, drop the valid once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (resampled.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_i_q    <= smp_i_q;
			out_q_q    <= smp_q_q;
			out_last_q <= emit_last;
		end
	end

	assign resampled.valid       = out_valid_q;
	assign resampled.out_i       = out_i_q;
	assign resampled.out_q       = out_q_q;
	assign resampled.last_of_run = out_last_q;

	// no owed output survives the end of an item
	a_idle_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !pend_q)
		else $error("owed output left behind in idle");

	// the run never grows past its bound
	a_run_bound: assert property (@(posedge clk) disable iff (!arst_n)
		run_cnt_q <= RUN_LIMIT)
		else $error("run counter past MAX_RUN");

	// an owed output is always counted in the run
	a_pend_counted: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_UP) && pend_q) |-> (run_cnt_q != '0))
		else $error("owed output not counted");

	// an emit is never made while the output register is held
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !resampled.ready) |-> !emit)
		else $error("held output overwritten");

endmodule
